// ===== rtl/rmdt_pkg.sv =====
`timescale 1ns / 1ps

package rmdt_pkg;

	// divider geometry: 64-bit dividend, 32-bit divisor
	localparam int unsigned DVD_W  = 64;
	localparam int unsigned DVR_W  = 32;
	localparam int unsigned STEP_W = $clog2(DVD_W);

	localparam logic [DVR_W-1:0] USEC_PER_SEC = 32'd1000000;
	localparam logic [DVD_W-1:0] USEC_BIAS    = 64'd999999;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WAIT  = 2'd1,
		ST_DONE  = 2'd2,
		ST_RETRY = 2'd3
	} status_t;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_POLL  = 1'b1
	} req_t;

	// control from the sequencer to the divider
	typedef struct packed {
		logic             start;
		logic [DVR_W-1:0] divisor;
	} div_ctl_t;

	// status from the divider back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== rtl/rmdt_div.sv =====
`timescale 1ns / 1ps

module rmdt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rmdt_pkg::div_ctl_t          ctl,
	input  logic [rmdt_pkg::DVD_W-1:0]  dividend,
	output rmdt_pkg::div_sts_t          sts,
	output logic [rmdt_pkg::DVD_W-1:0]  quot
);
	import rmdt_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVR_W-1:0]  rem_q;
	logic [DVR_W-1:0]  dvr_q;
	logic [DVD_W-1:0]  quot_q;
	logic [DVR_W:0]    trial;
	logic [DVR_W:0]    diff;
	logic              fits;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quot_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvr_q};
	assign fits  = trial >= {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= '0;
			dvr_q  <= ctl.divisor;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
			quot_q <= {quot_q[DVD_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = quot_q;

	assert property (@(posedge clk) disable iff (!arst_n) ctl.start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while still busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

// ===== rtl/rescaling_microsecond_delay_timer.sv =====
`timescale 1ns / 1ps

// Microsecond delay timer against a 32-bit free-running cycle counter whose
// frequency can change at run time.
// Input channel (in_valid/in_ready): one request per item, either a start
// (req_type 0) or a poll (req_type 1), with usec, the cycle counter sample
// and two frequency samples taken around it.
// Output channel (out_valid/out_ready): exactly one status per request:
// idle, waiting, done, or retry when the frequency samples disagree.
// From accept to status valid: requests that need no arithmetic go straight
// to the output, a poll at an unchanged frequency checks the wait first, a
// start does a multiply, bias add and a 64-step divide by one million, and a
// poll that sees a new frequency does the rescale multiply and divide (skipped
// when the old frequency was zero), then recomputes the wait. The next request
// can be taken in the cycle after the status is loaded.
// The 64-step restoring divider is shared by both divisions; one request is in
// flight at a time.
// The result sits in an output register: the next request is accepted while
// a status still waits, and a stalled receiver holds the block only when the
// next status is ready to go. Reset clears the wait in progress and all timing state.
module rescaling_microsecond_delay_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] usec,
	input  logic [31:0] cycle_count,
	input  logic [31:0] hz_first,
	input  logic [31:0] hz_second,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status
);
	import rmdt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_BIAS,
		S_DIVGO,
		S_DIVWAIT,
		S_CHECK,
		S_OUT
	} state_t;

	state_t state_q;

	// request captured at accept
	logic        req_q;
	logic [31:0] usec_q;
	logic [31:0] cyc_q;
	logic [31:0] hz1_q;
	logic [31:0] hz2_q;

	// timing state
	logic        busy_q;
	logic [31:0] ref_hz_q;
	logic [31:0] start_point_q;
	logic [31:0] wait_cycles_q;
	logic [31:0] wait_usec_q;

	// datapath
	logic        rescale_q;   // current divide is the start-point rescale
	logic [63:0] prod_q;
	status_t     res_q;
	logic        out_valid_q;
	status_t     status_q;

	logic [31:0] mul_a;
	logic [63:0] mul_p;
	logic [31:0] elapsed;
	logic        reached;
	logic [31:0] wait_sat;

	div_ctl_t    div_ctl;
	div_sts_t    div_sts;
	logic [63:0] div_quot;

	// shared multiplier: start point for a rescale, microseconds otherwise
	assign mul_a = rescale_q ? start_point_q : wait_usec_q;
	assign mul_p = 64'(mul_a) * 64'(hz1_q);

	// wrapping elapsed count against the wait
	assign elapsed = cyc_q - start_point_q;
	assign reached = elapsed >= wait_cycles_q;

	// a wait that overflows the counter saturates
	assign wait_sat = (div_quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quot[31:0];

	assign div_ctl.start   = (state_q == S_DIVGO);
	assign div_ctl.divisor = rescale_q ? ref_hz_q : USEC_PER_SEC;

	rmdt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (prod_q),
		.sts      (div_sts),
		.quot     (div_quot)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			busy_q        <= 1'b0;
			ref_hz_q      <= '0;
			start_point_q <= '0;
			wait_cycles_q <= '0;
			wait_usec_q   <= '0;
			rescale_q     <= 1'b0;
			prod_q        <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_IDLE;
			res_q         <= ST_IDLE;
		end else begin
			// output slot drains independently of the sequencer
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (req_q == REQ_START) begin
						if (usec_q == 32'd0) begin
							// zero-length start ends any wait at once
							busy_q  <= 1'b0;
							res_q   <= ST_DONE;
							state_q <= S_OUT;
						end else if (hz1_q != hz2_q) begin
							res_q   <= ST_RETRY;
							state_q <= S_OUT;
						end else begin
							ref_hz_q      <= hz1_q;
							start_point_q <= cyc_q;
							wait_usec_q   <= usec_q;
							busy_q        <= 1'b1;
							state_q       <= S_MUL;
						end
					end else if (!busy_q) begin
						res_q   <= ST_IDLE;
						state_q <= S_OUT;
					end else if (hz1_q != hz2_q) begin
						res_q   <= ST_RETRY;
						state_q <= S_OUT;
					end else if (hz1_q != ref_hz_q) begin
						// frequency moved: rescale start unless old rate was zero
						if (ref_hz_q != 32'd0) begin
							rescale_q <= 1'b1;
						end else begin
							ref_hz_q <= hz1_q;
						end
						state_q <= S_MUL;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_MUL: begin
					prod_q  <= mul_p;
					state_q <= rescale_q ? S_DIVGO : S_BIAS;
				end
				S_BIAS: begin
					// ceiling division by one million
					prod_q  <= prod_q + USEC_BIAS;
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIVWAIT;
				end
				S_DIVWAIT: begin
					if (div_sts.done) begin
						if (rescale_q) begin
							start_point_q <= div_quot[31:0];
							ref_hz_q      <= hz1_q;
							rescale_q     <= 1'b0;
							state_q       <= S_MUL;
						end else begin
							wait_cycles_q <= wait_sat;
							state_q       <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (reached) begin
						busy_q <= 1'b0;
						res_q  <= ST_DONE;
					end else begin
						res_q  <= ST_WAIT;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, payload only
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q  <= req_type;
			usec_q <= usec;
			cyc_q  <= cycle_count;
			hz1_q  <= hz_first;
			hz2_q  <= hz_second;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_DIVWAIT))
		else $error("divider result arrived outside its wait state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVWAIT) |-> (div_sts.busy || div_sts.done))
		else $error("waiting on an idle divider");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && reached) |=> !busy_q)
		else $error("wait reached but timer still busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_ctl.start && rescale_q) |-> (ref_hz_q != 32'd0))
		else $error("rescale divide by zero frequency");

endmodule

// ===== tb/delay_status_checker.sv =====
`timescale 1ns / 1ps

module delay_status_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] usec,
	input  logic [31:0] cycle_count,
	input  logic [31:0] hz_first,
	input  logic [31:0] hz_second,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	import rmdt_pkg::*;

	localparam logic [63:0] MICROS_PER_SEC = 64'd1_000_000;

	// shadow copy of the timer state
	logic        wait_active;
	logic [31:0] scale_hz;
	logic [31:0] origin_cycle;
	logic [31:0] target_cycles;
	logic [31:0] target_usec;

	status_t     status_due[$];
	status_t     expected;
	int          errors;
	int          seen;

	// ceiling of us * hz / 1e6, saturated to 32 bits
	function automatic logic [31:0] ceil_cycles(input logic [31:0] us, input logic [31:0] hz);
		logic [63:0] q;
		q = ({32'b0, us} * {32'b0, hz} + MICROS_PER_SEC - 64'd1) / MICROS_PER_SEC;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic status_t elapsed_status(input logic [31:0] now);
		logic [31:0] elapsed;
		elapsed = now - origin_cycle;
		if (elapsed >= target_cycles) begin
			wait_active = 1'b0;
			return ST_DONE;
		end
		return ST_WAIT;
	endfunction

	function automatic status_t next_status(input req_t kind, input logic [31:0] us,
			input logic [31:0] now, input logic [31:0] h1, input logic [31:0] h2);
		logic [63:0] scaled;
		if (kind == REQ_START) begin
			if (us == 32'd0) begin
				wait_active = 1'b0;
				return ST_DONE;
			end
			if (h1 != h2)
				return ST_RETRY;
			scale_hz      = h1;
			origin_cycle  = now;
			target_usec   = us;
			target_cycles = ceil_cycles(us, h1);
			wait_active   = 1'b1;
			return elapsed_status(now);
		end
		if (!wait_active)
			return ST_IDLE;
		if (h1 != h2)
			return ST_RETRY;
		// frequency moved: bring the start point and the wait to the new scale
		if (h1 != scale_hz) begin
			if (scale_hz != 32'd0) begin
				scaled       = ({32'b0, origin_cycle} * {32'b0, h1}) / {32'b0, scale_hz};
				origin_cycle = scaled[31:0];
			end
			scale_hz      = h1;
			target_cycles = ceil_cycles(target_usec, h1);
		end
		return elapsed_status(now);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_active   = 1'b0;
			scale_hz      = '0;
			origin_cycle  = '0;
			target_cycles = '0;
			target_usec   = '0;
			status_due.delete();
			errors        = 0;
			seen          = 0;
			fail_count   <= 0;
			pending      <= 0;
			checked      <= 0;
		end else begin
			// results first, so a status with nothing outstanding is caught
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					errors++;
					$error("status: expected none, actual %0d", status);
				end else begin
					expected = status_due.pop_front();
					seen++;
					if (status !== expected) begin
						errors++;
						$error("status: expected %s (%0d), actual %0d",
							expected.name(), expected, status);
					end
				end
			end
			if (in_valid && in_ready)
				status_due.push_back(next_status(req_t'(req_type), usec, cycle_count,
					hz_first, hz_second));
			fail_count <= errors;
			pending    <= status_due.size();
			checked    <= seen;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import rmdt_pkg::*;

	// cycles with no handshake on either side before the run is declared hung;
	// the slowest request is a rescaling poll
	localparam int STALL_LIMIT    = 5000;
	localparam int REQUEST_TARGET = 1325;
	localparam int DRAIN_CYCLES   = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [31:0] usec;
	logic [31:0] cycle_count;
	logic [31:0] hz_first;
	logic [31:0] hz_second;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;

	int fail_count;
	int pending;
	int checked;

	int requests_sent;
	int starts_sent;
	int polls_sent;
	int stall_cycles;
	// window of requests during which neither side idles
	bit steady;

	rescaling_microsecond_delay_timer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.usec        (usec),
		.cycle_count (cycle_count),
		.hz_first    (hz_first),
		.hz_second   (hz_second),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status)
	);

	delay_status_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.usec        (usec),
		.cycle_count (cycle_count),
		.hz_first    (hz_first),
		.hz_second   (hz_second),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure outside the steady window, ready dropped with a chance of 8 in 100
	always @(negedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 8);
	end

	// hang detector: no request or status moving for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: nothing moved for %0d cycles, %0d statuses outstanding",
					stall_cycles, pending);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// one request: optional idle gap, then hold valid until accepted
	task automatic send_request(input req_t kind, input logic [31:0] us, input logic [31:0] cc,
			input logic [31:0] h1, input logic [31:0] h2);
		if (!steady) begin
			while ($urandom_range(0, 99) < 8) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		usec        <= us;
		cycle_count <= cc;
		hz_first    <= h1;
		hz_second   <= h2;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		requests_sent++;
		if (kind == REQ_START)
			starts_sent++;
		else
			polls_sent++;
		steady = (requests_sent >= 500 && requests_sent < 800);
	endtask

	// mostly typical counter clocks, sometimes odd or extreme ones
	function automatic logic [31:0] pick_hz();
		case ($urandom_range(0, 9))
			0:       return 32'd1_000_000;
			1:       return 32'd19_200_000;
			2:       return 32'd24_000_000;
			3:       return 32'd32_768;
			4:       return 32'd100_000_000;
			5:       return 32'd3_000_000_000;
			6, 7, 8: return $urandom;
			default: return $urandom_range(1, 1000);
		endcase
	endfunction

	// rough cycle span of a wait, only to pace the cycle count of polls
	function automatic longint unsigned cycle_span(input logic [31:0] us, input logic [31:0] hz);
		longint unsigned s;
		s = (64'(us) * 64'(hz)) / 64'd1_000_000;
		return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
	endfunction

	task automatic run_directed();
		// poll with nothing running, samples even disagree
		send_request(REQ_POLL,  32'd0, 32'd0, 32'd5, 32'd6);
		// zero-length start, samples not looked at
		send_request(REQ_START, 32'd0, 32'd7, 32'd1, 32'd2);
		// inconsistent sample on a start
		send_request(REQ_START, 32'd10, 32'd100, 32'd1_000_000, 32'd1_000_001);
		// 10 us at 1 MHz from counter value 100
		send_request(REQ_START, 32'd10, 32'd100, 32'd1_000_000, 32'd1_000_000);
		send_request(REQ_POLL,  32'd0, 32'd105, 32'd1_000_000, 32'd2_000_000);
		send_request(REQ_POLL,  32'd0, 32'd105, 32'd1_000_000, 32'd1_000_000);
		// clock doubles: start moves to 200 and the wait doubles with it
		send_request(REQ_POLL,  32'd0, 32'd210, 32'd2_000_000, 32'd2_000_000);
		send_request(REQ_POLL,  32'd0, 32'd220, 32'd2_000_000, 32'd2_000_000);
		send_request(REQ_POLL,  32'd0, 32'd221, 32'd2_000_000, 32'd2_000_000);
		// wait that straddles the counter wrap, then replaced by a shorter one
		send_request(REQ_START, 32'd100, 32'hFFFF_FFF0, 32'd1_000_000, 32'd1_000_000);
		send_request(REQ_START, 32'd5, 32'hFFFF_FFFE, 32'd1_000_000, 32'd1_000_000);
		send_request(REQ_POLL,  32'd0, 32'd3, 32'd1_000_000, 32'd1_000_000);
		// longest wait: saturates at the full counter range
		send_request(REQ_START, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_POLL,  32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_POLL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// zero frequency gives a zero wait, finished at once
		send_request(REQ_START, 32'd1, 32'd9, 32'd0, 32'd0);
		send_request(REQ_POLL,  32'd0, 32'd9, 32'd0, 32'd0);
		// rescale to zero frequency mid-wait
		send_request(REQ_START, 32'd1000, 32'd50, 32'd1_000_000, 32'd1_000_000);
		send_request(REQ_POLL,  32'd0, 32'd60, 32'd0, 32'd0);
		// zero-length start cancels a running wait
		send_request(REQ_START, 32'd7, 32'd5, 32'd3, 32'd3);
		send_request(REQ_START, 32'd0, 32'd6, 32'd3, 32'd3);
		send_request(REQ_POLL,  32'd0, 32'd6, 32'd3, 32'd3);
		// sub-cycle wait rounds up to one cycle
		send_request(REQ_START, 32'd1, 32'd9, 32'd1, 32'd1);
		send_request(REQ_POLL,  32'd0, 32'd10, 32'd1, 32'd1);
		// rescale up whose product overflows 32 bits and gets truncated
		send_request(REQ_START, 32'd3, 32'hFFFF_FFF0, 32'd1, 32'd1);
		send_request(REQ_POLL,  32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// a start followed by polls that walk the counter toward the end of the wait,
	// with clock changes, torn samples, restarts and some junk mixed in
	task automatic run_wait_sequence();
		logic [31:0]     hz;
		logic [31:0]     new_hz;
		logic [31:0]     us;
		logic [31:0]     cc;
		longint unsigned span;
		int              roll;
		int              polls;
		hz = pick_hz();
		case ($urandom_range(0, 9))
			0:       us = $urandom;
			1:       us = $urandom_range(0, 3);
			default: us = $urandom_range(1, 2000);
		endcase
		cc   = $urandom;
		span = cycle_span(us, hz);
		if ($urandom_range(0, 19) == 0)
			send_request(REQ_START, us, cc, hz, hz ^ (32'd1 << $urandom_range(0, 31)));
		send_request(REQ_START, us, cc, hz, hz);
		polls = $urandom_range(1, 8);
		repeat (polls) begin
			roll = $urandom_range(0, 99);
			if (roll < 78) begin
				cc += $urandom_range(0, 32'(span / 3 + 2));
				send_request(REQ_POLL, $urandom, cc, hz, hz);
			end else if (roll < 86) begin
				// counter clock changes; counter value follows roughly
				new_hz = pick_hz();
				cc     = 32'((64'(cc) * 64'(new_hz)) / ((hz == 32'd0) ? 64'd1 : 64'(hz)));
				hz     = new_hz;
				span   = cycle_span(us, hz);
				send_request(REQ_POLL, $urandom, cc, hz, hz);
			end else if (roll < 92) begin
				send_request(REQ_POLL, $urandom, cc, hz, hz ^ (32'd1 << $urandom_range(0, 31)));
			end else if (roll < 96) begin
				us   = $urandom_range(1, 2000);
				span = cycle_span(us, hz);
				send_request(REQ_START, us, cc, hz, hz);
			end else begin
				send_request(req_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
					$urandom_range(0, 1) ? hz : $urandom);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = REQ_START;
		usec          = '0;
		cycle_count   = '0;
		hz_first      = '0;
		hz_second     = '0;
		out_ready     = 1'b0;
		requests_sent = 0;
		starts_sent   = 0;
		polls_sent    = 0;
		stall_cycles  = 0;
		steady        = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		while (requests_sent < REQUEST_TARGET)
			run_wait_sequence();
		in_valid <= 1'b0;

		// drain outstanding statuses, then watch for strays
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d requests (%0d starts, %0d polls), %0d statuses checked",
			requests_sent, starts_sent, polls_sent, checked);
		$display("run: corner cases, then wait sequences with wrap, rescale, retry and restart");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
